// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Include with the bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define CHK_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: hw/rtl/mgbp_pkg.sv
// Package of the bilinear prolongation core: sizes, codes, payload and tag types.
// No dependencies; every RTL file of the block imports it.
package mgbp_pkg;

	// Grid geometry. The refinement factor is a power of two.
	localparam int MAX_COARSE  = 64;
	localparam int FACTOR_LOG2 = 1;
	localparam int FACTOR      = 1 << FACTOR_LOG2;
	localparam int CIDX_W      = $clog2(MAX_COARSE);
	localparam int DEPTH       = MAX_COARSE * MAX_COARSE;
	localparam int ADDR_W      = $clog2(DEPTH);

	// Field widths.
	localparam int IDX_W  = 8;
	localparam int VAL_W  = 32;
	localparam int OUT_W  = 34;
	localparam int SIZE_W = 7;
	localparam int NW     = SIZE_W + 1;
	localparam int FIDX_W = IDX_W + 1;
	localparam int FT_W   = NW + FACTOR_LOG2;

	// Configuration register.
	localparam int PADDR_W     = 3;
	localparam int REG_IDX_LSB = 2;
	localparam logic REG_COARSE_SIZE = 1'b0;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
	localparam logic [NW-1:0]     SIZE_MIN   = 8'd3;

	// Operation codes.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic                    op;
		logic [IDX_W-1:0]        col;
		logic [IDX_W-1:0]        row;
		logic signed [VAL_W-1:0] coarse_value;
	} req_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] fine_value;
		logic                    in_interior;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN
	} state_t;

	// One coarse neighbor along one axis.
	typedef struct packed {
		logic              vld;
		logic [FIDX_W-1:0] idx;
		logic              dbl;
	} slot_t;

	// Control that travels with each store read to the accumulator.
	typedef struct packed {
		logic       clear;
		logic       vld;
		logic [1:0] shift;
		logic       last;
		logic       zero_res;
	} tag_t;

endpackage

// File: hw/rtl/multigrid_bilinear_prolongation_core.sv
// Top level of the bilinear multigrid prolongation core.
// Depends on mgbp_pkg, mgbp_seq, mgbp_store and mgbp_accum.
//
//   channel   handshake                 payload
//   request   start / busy              req   (req_t)
//   result    done strobe, no stall     res   (res_t)
//   config    APB psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// A sample write does not raise busy; a new request may follow in the next cycle.
// An interior query holds busy through four read steps, one per cycle on the
// single read port (a step reads only when both neighbors are valid), then a
// drain state; the result passes the sequencer tag and the result register.
// A query outside the interior does not raise busy. Reset clears control only;
// the store holds no defined value until written and gets no clearing pass.
module multigrid_bilinear_prolongation_core import mgbp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  req_t               req,
	output logic               done,
	output res_t               res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [SIZE_W-1:0]       coarse_size_q;
	logic [NW-1:0]           size_ext;
	logic [NW-1:0]           n_eff;
	logic                    wr_en, rd_en;
	logic [ADDR_W-1:0]       wr_addr, rd_addr;
	logic signed [VAL_W-1:0] wr_data, rd_data;
	tag_t                    tag_s1;

	// Configuration register.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coarse_size_q <= SIZE_RESET;
		end else if (psel && penable && pwrite &&
				(paddr[REG_IDX_LSB] == REG_COARSE_SIZE)) begin
			coarse_size_q <= pwdata[SIZE_W-1:0];
		end
	end
	assign prdata = (paddr[REG_IDX_LSB] == REG_COARSE_SIZE) ?
		32'(coarse_size_q) : 32'd0;

	// Effective grid size, clamped to the supported range.
	assign size_ext = NW'(coarse_size_q);
	always_comb begin
		if (size_ext < SIZE_MIN) begin
			n_eff = SIZE_MIN;
		end else if (size_ext > NW'(MAX_COARSE)) begin
			n_eff = NW'(MAX_COARSE);
		end else begin
			n_eff = size_ext;
		end
	end

	mgbp_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.n_eff   (n_eff),
		.busy    (busy),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.tag_s1  (tag_s1)
	);

	mgbp_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	mgbp_accum u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_s1  (tag_s1),
		.rd_data (rd_data),
		.done    (done),
		.res     (res)
	);

endmodule

// File: hw/rtl/mgbp_store.sv
// Coarse sample store: one write port, one read port, registered read data.
// Depends on mgbp_pkg for depth and widths.
module mgbp_store import mgbp_pkg::*; (
	input  logic                    clk,
	input  logic                    wr_en,
	input  logic [ADDR_W-1:0]       wr_addr,
	input  logic signed [VAL_W-1:0] wr_data,
	input  logic                    rd_en,
	input  logic [ADDR_W-1:0]       rd_addr,
	output logic signed [VAL_W-1:0] rd_data
);

	logic signed [VAL_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hw/rtl/mgbp_seq.sv
// Request sequencer: decodes requests, writes samples, walks the neighbor reads.
// Depends on mgbp_pkg; drives the store and the accumulator tag.
module mgbp_seq import mgbp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  req_t                    req,
	input  logic [NW-1:0]           n_eff,
	output logic                    busy,
	output logic                    wr_en,
	output logic [ADDR_W-1:0]       wr_addr,
	output logic signed [VAL_W-1:0] wr_data,
	output logic                    rd_en,
	output logic [ADDR_W-1:0]       rd_addr,
	output tag_t                    tag_s1
);

	state_t     state_q, state_d;
	logic [1:0] k_q;
	slot_t      cslot_q [2];
	slot_t      rslot_q [2];
	slot_t      cslot_sel, rslot_sel;
	logic       accept, query, interior;
	logic [FT_W-1:0] fine_top;
	tag_t       tag_d;

	// Neighbor along one axis. The lower slot is the coinciding point or the
	// one just below; the upper slot is the one just above.
	function automatic slot_t coarse_slot(input logic [IDX_W-1:0] f,
			input logic [NW-1:0] n, input logic upper);
		logic [FIDX_W-1:0] fz, fm, fp;
		slot_t s;
		fz = FIDX_W'(f);
		fm = fz - FIDX_W'(1);
		fp = fz + FIDX_W'(1);
		s.vld = 1'b0;
		s.dbl = 1'b0;
		s.idx = fz >> FACTOR_LOG2;
		if (upper) begin
			s.vld = (fp[FACTOR_LOG2-1:0] == '0);
			s.idx = fp >> FACTOR_LOG2;
		end else if (fz[FACTOR_LOG2-1:0] == '0) begin
			s.vld = 1'b1;
			s.dbl = 1'b1;
		end else if (fm[FACTOR_LOG2-1:0] == '0) begin
			s.vld = 1'b1;
			s.idx = fm >> FACTOR_LOG2;
		end
		// Only interior coarse points contribute.
		s.vld = s.vld && (s.idx != '0) && ((s.idx + FIDX_W'(2)) <= FIDX_W'(n));
		return s;
	endfunction

	function automatic logic [ADDR_W-1:0] store_addr(input logic [CIDX_W-1:0] r,
			input logic [CIDX_W-1:0] c);
		return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_COARSE)) + ADDR_W'(c);
	endfunction

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign query  = (req.op == OP_QUERY);

	// Interior test of the fine point.
	assign fine_top = FT_W'(n_eff - NW'(1)) << FACTOR_LOG2;
	assign interior = (req.col != '0) && (req.row != '0) &&
		(FT_W'(req.col) < fine_top) && (FT_W'(req.row) < fine_top);

	// Sample writes go straight to the store; out-of-range ones are dropped.
	assign wr_en   = accept && !query && (req.col < IDX_W'(MAX_COARSE)) &&
		(req.row < IDX_W'(MAX_COARSE));
	assign wr_addr = store_addr(req.row[CIDX_W-1:0], req.col[CIDX_W-1:0]);
	assign wr_data = req.coarse_value;

	// Neighbor read selected by the step counter.
	assign cslot_sel = cslot_q[k_q[0]];
	assign rslot_sel = rslot_q[k_q[1]];
	assign rd_en     = (state_q == ST_READ) && cslot_sel.vld && rslot_sel.vld;
	assign rd_addr   = store_addr(rslot_sel.idx[CIDX_W-1:0], cslot_sel.idx[CIDX_W-1:0]);

	// Next state and the tag for the accumulator.
	always_comb begin
		state_d        = state_q;
		tag_d.clear    = 1'b0;
		tag_d.vld      = 1'b0;
		tag_d.shift    = 2'(cslot_sel.dbl) + 2'(rslot_sel.dbl);
		tag_d.last     = 1'b0;
		tag_d.zero_res = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && query) begin
					if (interior) begin
						state_d     = ST_READ;
						tag_d.clear = 1'b1;
					end else begin
						tag_d.zero_res = 1'b1;
					end
				end
			end
			ST_READ: begin
				tag_d.vld  = rd_en;
				tag_d.last = (k_q == 2'd3);
				if (k_q == 2'd3) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			tag_s1  <= '0;
		end else begin
			state_q <= state_d;
			tag_s1  <= tag_d;
			if (state_q == ST_READ) begin
				k_q <= k_q + 2'd1;
			end else begin
				k_q <= '0;
			end
		end
	end

	// Neighbor slots captured whenever a request is taken; only queries use them.
	always_ff @(posedge clk) begin
		if (accept) begin
			cslot_q[0] <= coarse_slot(req.col, n_eff, 1'b0);
			cslot_q[1] <= coarse_slot(req.col, n_eff, 1'b1);
			rslot_q[0] <= coarse_slot(req.row, n_eff, 1'b0);
			rslot_q[1] <= coarse_slot(req.row, n_eff, 1'b1);
		end
	end

endmodule

// File: hw/rtl/mgbp_accum.sv
// Accumulator and result register of the prolongation core.
// Depends on mgbp_pkg; fed by the store read data and the sequencer tag.
module mgbp_accum import mgbp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tag_t                    tag_s1,
	input  logic signed [VAL_W-1:0] rd_data,
	output logic                    done,
	output res_t                    res
);

	logic signed [OUT_W-1:0] acc_q;
	logic signed [OUT_W-1:0] term;
	logic signed [OUT_W-1:0] sum;

	// Weights are 1, 2 or 4, so each contribution is a shift.
	assign term = tag_s1.vld ? (OUT_W'(rd_data) <<< tag_s1.shift) : '0;
	assign sum  = acc_q + term;

	always_ff @(posedge clk) begin
		if (tag_s1.clear) begin
			acc_q <= '0;
		end else begin
			acc_q <= sum;
		end
	end

	// Result strobe lasts one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= tag_s1.last || tag_s1.zero_res;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s1.zero_res) begin
			res.fine_value  <= '0;
			res.in_interior <= 1'b0;
		end else if (tag_s1.last) begin
			res.fine_value  <= sum;
			res.in_interior <= 1'b1;
		end
	end

endmodule

// File: hw/rtl/mgbp_checker.sv
// Port-level checker of the prolongation core, bound to the top level.
// Depends on mgbp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mgbp_checker import mgbp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t req,
	input logic done,
	input res_t res
);

	// A sample write never holds off the next request.
	`CHK_ASSERT(a_write_no_busy, clk, arst_n, start && !busy && (req.op == OP_WRITE) |=> !busy, "write request raised busy")

	// Busy only starts on a query request.
	`CHK_ASSERT(a_busy_from_query, clk, arst_n, $rose(busy) |-> $past(start && (req.op == OP_QUERY)), "busy rose without a query request")

	// The end of a gather always delivers its result.
	`CHK_ASSERT(a_result_at_end, clk, arst_n, $fell(busy) |-> done, "gather ended without a result")

	// A point outside the interior reads as zero.
	`CHK_NEVER(a_outside_zero, clk, arst_n, done && !res.in_interior && (res.fine_value != '0), "nonzero value outside the interior")

endmodule

bind multigrid_bilinear_prolongation_core mgbp_checker u_chk (.*);

// File: dv/tb_multigrid_bilinear_prolongation_core.sv
// Self-checking testbench of the bilinear multigrid prolongation core.
// Uses mgbp_pkg and multigrid_bilinear_prolongation_core; needs nothing else.
// Directed table first, then random phases over several coarse sizes.
module tb_multigrid_bilinear_prolongation_core;
	import mgbp_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 10;
	localparam int PHASE_ITEMS = 100;
	localparam int NUM_PHASES = 11;
	localparam int NUM_ROWS = 20;

	// One row of the directed table; typed rows carry their own expected result.
	typedef struct packed {
		logic op;
		logic [IDX_W-1:0] col;
		logic [IDX_W-1:0] row;
		logic [VAL_W-1:0] value;
		logic typed;
		logic [OUT_W-1:0] fine;
		logic interior;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic busy;
	logic done;
	res_t res;
	logic [31:0] prdata;
	logic pready;

	// Shadow of the block: coarse samples, which of them were written, and the size register.
	logic signed [VAL_W-1:0] coarse_mem [0:DEPTH-1];
	bit written [0:DEPTH-1];
	logic [SIZE_W-1:0] size_shadow = SIZE_RESET;
	res_t fine_q [$];
	int fails = 0;
	int idle_cycles = 0;
	plan_row_t plan [0:NUM_ROWS-1];

	multigrid_bilinear_prolongation_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #6 clk = ~clk;

	// Coarse size as the block uses it, after clamping.
	function automatic int eff_size();
		if (size_shadow < 3) return 3;
		if (size_shadow > MAX_COARSE) return MAX_COARSE;
		return int'(size_shadow);
	endfunction

	// Expected fine sample: weighted sum of the nearby interior coarse samples.
	function automatic res_t prolong_point(logic [IDX_W-1:0] fc, logic [IDX_W-1:0] fr);
		int n, top, dx, dy, xc, yr, i, j, wx, wy;
		longint acc;
		res_t r;
		n = eff_size();
		top = FACTOR * (n - 1);
		r = '0;
		acc = 0;
		if (fc < 1 || fr < 1 || fc >= top || fr >= top) return r;
		for (dy = -1; dy <= 1; dy++) begin
			yr = int'(fr) - dy;
			if (yr < 0 || (yr % FACTOR) != 0) continue;
			j = yr / FACTOR;
			if (j < 1 || j > n - 2) continue;
			wy = (dy == 0) ? 2 : 1;
			for (dx = -1; dx <= 1; dx++) begin
				xc = int'(fc) - dx;
				if (xc < 0 || (xc % FACTOR) != 0) continue;
				i = xc / FACTOR;
				if (i < 1 || i > n - 2) continue;
				wx = (dx == 0) ? 2 : 1;
				acc += longint'(coarse_mem[j * MAX_COARSE + i]) * wx * wy;
			end
		end
		r.fine_value = acc[OUT_W-1:0];
		r.in_interior = 1'b1;
		return r;
	endfunction

	// Store entry that a query would read although it was never written, or -1 if none.
	function automatic int first_unwritten(logic [IDX_W-1:0] fc, logic [IDX_W-1:0] fr, int n);
		int top, dx, dy, xc, yr, i, j;
		top = FACTOR * (n - 1);
		if (fc < 1 || fr < 1 || fc >= top || fr >= top) return -1;
		for (dy = -1; dy <= 1; dy++) begin
			yr = int'(fr) - dy;
			if (yr < 0 || (yr % FACTOR) != 0) continue;
			j = yr / FACTOR;
			if (j < 1 || j > n - 2) continue;
			for (dx = -1; dx <= 1; dx++) begin
				xc = int'(fc) - dx;
				if (xc < 0 || (xc % FACTOR) != 0) continue;
				i = xc / FACTOR;
				if (i < 1 || i > n - 2) continue;
				if (!written[j * MAX_COARSE + i]) return j * MAX_COARSE + i;
			end
		end
		return -1;
	endfunction

	function automatic plan_row_t mk_row(logic op, int col, int row, logic [VAL_W-1:0] value,
			logic typed, logic [OUT_W-1:0] fine, logic interior);
		plan_row_t p;
		p.op = op;
		p.col = col[IDX_W-1:0];
		p.row = row[IDX_W-1:0];
		p.value = value;
		p.typed = typed;
		p.fine = fine;
		p.interior = interior;
		return p;
	endfunction

	// Mostly back to back, sometimes short pauses, rarely long ones.
	function automatic int idle_gap(bit no_idle);
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Random request aimed at the current grid, with some noise outside it.
	// A query that would touch a sample never written loads that sample instead.
	function automatic req_t random_request(int n);
		req_t r;
		int top, pick, miss;
		top = FACTOR * (n - 1);
		r = '0;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 40) begin
			r.op = OP_WRITE;
			if (pick < 85) begin
				r.col = IDX_W'($urandom_range(0, n - 1));
				r.row = IDX_W'($urandom_range(0, n - 1));
			end else if (pick < 95) begin
				r.col = IDX_W'($urandom_range(0, MAX_COARSE - 1));
				r.row = IDX_W'($urandom_range(0, MAX_COARSE - 1));
			end else begin
				r.col = IDX_W'($urandom_range(0, 255));
				r.row = IDX_W'($urandom_range(MAX_COARSE, 255));
				if ($urandom_range(0, 1)) {r.col, r.row} = {r.row, r.col};
			end
			pick = $urandom_range(0, 9);
			if (pick == 0) r.coarse_value = 32'h7FFF_FFFF;
			else if (pick == 1) r.coarse_value = 32'h8000_0000;
			else r.coarse_value = $urandom;
		end else begin
			r.op = OP_QUERY;
			r.coarse_value = $urandom;
			if (pick < 80) begin
				r.col = IDX_W'($urandom_range(0, top));
				r.row = IDX_W'($urandom_range(0, top));
			end else if (pick < 90) begin
				r.col = IDX_W'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 1)
					: $urandom_range(top - 1, top));
				r.row = IDX_W'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 1)
					: $urandom_range(top - 1, top));
			end else begin
				r.col = IDX_W'($urandom_range(0, 255));
				r.row = IDX_W'($urandom_range(0, 255));
			end
			miss = first_unwritten(r.col, r.row, n);
			if (miss >= 0) begin
				r.op = OP_WRITE;
				r.col = IDX_W'(miss % MAX_COARSE);
				r.row = IDX_W'(miss / MAX_COARSE);
			end
		end
		return r;
	endfunction

	// Present one request, wait for its acceptance, then update the shadow.
	task automatic issue(input req_t r, input bit no_idle, input bit typed, input res_t typed_res);
		int gap;
		start <= 1'b1;
		req <= r;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		if (r.op == OP_WRITE) begin
			if (r.col < MAX_COARSE && r.row < MAX_COARSE) begin
				coarse_mem[int'(r.row) * MAX_COARSE + int'(r.col)] = r.coarse_value;
				written[int'(r.row) * MAX_COARSE + int'(r.col)] = 1'b1;
			end
		end else begin
			fine_q.push_back(typed ? typed_res : prolong_point(r.col, r.row));
		end
		gap = idle_gap(no_idle);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off until every expected result is in and the block has gone quiet.
	task automatic drain();
		start <= 1'b0;
		while (fine_q.size() != 0) @(posedge clk);
		@(negedge clk);
		while (busy) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write of the coarse size register: setup cycle, then access cycle.
	task automatic write_size(input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(REG_COARSE_SIZE) << REG_IDX_LSB;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		@(posedge clk);
		size_shadow = value[SIZE_W-1:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Result checker: every strobe is matched against the oldest expectation.
	always @(negedge clk) begin
		res_t want;
		if (arst_n && done) begin
			if (fine_q.size() == 0) begin
				$error("result with nothing expected: fine_value %0d, in_interior %0b",
					res.fine_value, res.in_interior);
				fails++;
			end else begin
				want = fine_q.pop_front();
				if (res.fine_value !== want.fine_value) begin
					$error("fine_value mismatch: expected %0d, actual %0d",
						want.fine_value, res.fine_value);
					fails++;
				end
				if (res.in_interior !== want.in_interior) begin
					$error("in_interior mismatch: expected %0b, actual %0b",
						want.in_interior, res.in_interior);
					fails++;
				end
			end
		end
	end

	// Watchdog on cycles in which no request and no result is accepted.
	always @(negedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		req_t r;
		res_t typed_res;
		int phase_size [0:NUM_PHASES-1];
		int k, ph, a;

		for (a = 0; a < DEPTH; a++) coarse_mem[a] = '0;

		// Directed rows at the reset size of 64. Every query reads only samples
		// that an earlier row has written.
		plan[0]  = mk_row(OP_QUERY, 0, 0, 32'h0, 1, 34'h0, 0);
		plan[1]  = mk_row(OP_QUERY, 255, 255, 32'hFFFF_FFFF, 1, 34'h0, 0);
		plan[2]  = mk_row(OP_QUERY, 126, 5, 32'h0, 1, 34'h0, 0);
		plan[3]  = mk_row(OP_QUERY, 5, 0, 32'h0, 1, 34'h0, 0);
		plan[4]  = mk_row(OP_WRITE, 1, 1, 32'h7FFF_FFFF, 0, 34'h0, 0);
		plan[5]  = mk_row(OP_QUERY, 2, 2, 32'h0, 1, 34'h1_FFFF_FFFC, 1);
		plan[6]  = mk_row(OP_WRITE, 1, 1, 32'h8000_0000, 0, 34'h0, 0);
		plan[7]  = mk_row(OP_QUERY, 2, 2, 32'h0, 1, 34'h2_0000_0000, 1);
		plan[8]  = mk_row(OP_QUERY, 1, 1, 32'h0, 1, 34'h3_8000_0000, 1);
		plan[9]  = mk_row(OP_WRITE, 2, 1, 32'h0001_0000, 0, 34'h0, 0);
		plan[10] = mk_row(OP_WRITE, 1, 2, 32'hFFFF_0000, 0, 34'h0, 0);
		plan[11] = mk_row(OP_WRITE, 2, 2, 32'h1234_5678, 0, 34'h0, 0);
		plan[12] = mk_row(OP_QUERY, 3, 2, 32'h0, 0, 34'h0, 0);
		plan[13] = mk_row(OP_QUERY, 3, 3, 32'h0, 0, 34'h0, 0);
		plan[14] = mk_row(OP_WRITE, 255, 255, 32'h1234_5678, 0, 34'h0, 0);
		plan[15] = mk_row(OP_WRITE, 64, 3, 32'hDEAD_BEEF, 0, 34'h0, 0);
		plan[16] = mk_row(OP_WRITE, 62, 62, 32'h7FFF_FFFF, 0, 34'h0, 0);
		plan[17] = mk_row(OP_QUERY, 124, 124, 32'h0, 1, 34'h1_FFFF_FFFC, 1);
		plan[18] = mk_row(OP_QUERY, 125, 125, 32'h0, 0, 34'h0, 0);
		plan[19] = mk_row(OP_QUERY, 126, 1, 32'h0, 1, 34'h0, 0);

		phase_size[0] = 3;
		phase_size[1] = 127;
		phase_size[2] = 0;
		phase_size[3] = 1;
		phase_size[4] = 2;
		phase_size[5] = 64;
		phase_size[6] = 5;
		for (ph = 7; ph < NUM_PHASES; ph++) phase_size[ph] = $urandom_range(3, 64);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed table.
		for (k = 0; k < NUM_ROWS; k++) begin
			r.op = plan[k].op;
			r.col = plan[k].col;
			r.row = plan[k].row;
			r.coarse_value = plan[k].value;
			typed_res.fine_value = plan[k].fine;
			typed_res.in_interior = plan[k].interior;
			issue(r, 1'b0, plan[k].typed, typed_res);
		end

		// Random phases, each at its own coarse size, written while idle.
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			write_size(32'(phase_size[ph]) | ({$urandom} & 32'hFFFF_FF80));
			for (k = 0; k < PHASE_ITEMS; k++)
				issue(random_request(eff_size()), (ph % 4) == 3, 1'b0, '0);
		end

		drain();
		if (fails == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
